FILE: src/surround_obstacle_stop_guard_macros.svh
// assertion macros for the surround obstacle stop guard
// uses clk and rst of the module that includes it
`ifndef SURROUND_OBSTACLE_STOP_GUARD_MACROS_SVH
`define SURROUND_OBSTACLE_STOP_GUARD_MACROS_SVH

// consequence must hold in the same cycle
`define SOSG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence must hold in the following cycle
`define SOSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sosg_pkg.sv
// shared types and constants of the surround obstacle stop guard
// no dependencies
`default_nettype none

package sosg_pkg;

  localparam int POINT_W  = 20;
  localparam int SPEED_W  = 17;
  localparam int OFFSET_W = 16;
  localparam int DIST_W   = 40;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int STOP_ENTRY_TICKS = 1;

  localparam logic [DIST_W-1:0] DIST_ONES = '1;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRONT_OFFSET     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REAR_OFFSET      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFFSET      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFFSET     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_DISTANCE   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_DISTANCE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_TICKS      = 4'd7;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_LIMIT = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    logic signed [OFFSET_W-1:0] front_offset;
    logic signed [OFFSET_W-1:0] rear_offset;
    logic signed [OFFSET_W-1:0] left_offset;
    logic signed [OFFSET_W-1:0] right_offset;
    logic [OFFSET_W-1:0]        check_distance;
    logic [OFFSET_W-1:0]        recover_distance;
    logic [OFFSET_W-1:0]        stop_speed;
    logic [CNT_W-1:0]           clear_ticks;
  } cfg_t;

  // item handed from the front part to the back part
  typedef struct packed {
    logic                      kind;
    logic [DIST_W-1:0]         dist_sq;
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic signed [SPEED_W-1:0] speed;
  } q_item_t;

  typedef struct packed {
    logic                      stop_active;
    cmd_t                      command;
    logic                      obstacle_found;
    logic [DIST_W-1:0]         nearest_dist_sq;
    logic signed [POINT_W-1:0] nearest_x;
    logic signed [POINT_W-1:0] nearest_y;
  } result_t;

endpackage

`default_nettype wire

FILE: src/sosg_front.sv
// front part: takes items, computes rectangle gaps and the squared distance
// depends on sosg_pkg
`default_nettype none

module sosg_front import sosg_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cfg_t                      cfg,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic                      kind,
  input  wire logic signed [POINT_W-1:0] point_x,
  input  wire logic signed [POINT_W-1:0] point_y,
  input  wire logic signed [SPEED_W-1:0] ego_speed,
  output logic                           q_push,
  output q_item_t                        q_item,
  input  wire logic                      q_full
);

  typedef struct packed {
    logic                      kind;
    logic [POINT_W-1:0]        dx;
    logic [POINT_W-1:0]        dy;
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic signed [SPEED_W-1:0] speed;
  } gap_stage_t;

  typedef struct packed {
    logic                      kind;
    logic [DIST_W-1:0]         sq_x;
    logic [DIST_W-1:0]         sq_y;
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic signed [SPEED_W-1:0] speed;
  } sq_stage_t;

  // distance beyond the [lo, hi] interval, zero inside; max gap fits 20 bits
  function automatic logic [POINT_W-1:0] axis_gap(
    input logic signed [POINT_W-1:0]  p,
    input logic signed [OFFSET_W-1:0] hi,
    input logic signed [OFFSET_W-1:0] lo
  );
    logic signed [POINT_W+1:0] a;
    logic signed [POINT_W+1:0] b;
    logic signed [POINT_W+1:0] g;
    a = (POINT_W+2)'(p) - (POINT_W+2)'(hi);
    b = (POINT_W+2)'(lo) - (POINT_W+2)'(p);
    g = '0;
    if (a > g) g = a;
    if (b > g) g = b;
    return g[POINT_W-1:0];
  endfunction

  logic       v1, v2, adv;
  gap_stage_t s1;
  sq_stage_t  s2;
  logic [DIST_W:0] dist_sum;

  assign adv  = !v2 || !q_full;
  assign full = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.kind  <= kind;
      s1.dx    <= axis_gap(point_x, cfg.front_offset, cfg.rear_offset);
      s1.dy    <= axis_gap(point_y, cfg.left_offset, cfg.right_offset);
      s1.x     <= point_x;
      s1.y     <= point_y;
      s1.speed <= ego_speed;
      s2.kind  <= s1.kind;
      s2.sq_x  <= DIST_W'(s1.dx) * DIST_W'(s1.dx);
      s2.sq_y  <= DIST_W'(s1.dy) * DIST_W'(s1.dy);
      s2.x     <= s1.x;
      s2.y     <= s1.y;
      s2.speed <= s1.speed;
    end
  end

  // sum saturates at the 40 bit ceiling
  assign dist_sum = {1'b0, s2.sq_x} + {1'b0, s2.sq_y};

  always_comb begin
    q_push         = v2 && !q_full;
    q_item.kind    = s2.kind;
    q_item.dist_sq = dist_sum[DIST_W] ? DIST_ONES : dist_sum[DIST_W-1:0];
    q_item.x       = s2.x;
    q_item.y       = s2.y;
    q_item.speed   = s2.speed;
  end

endmodule

`default_nettype wire

FILE: src/sosg_queue.sv
// short queue between the front and back parts
// depends on sosg_pkg
`default_nettype none

module sosg_queue import sosg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire q_item_t push_item,
  output logic         full,
  input  wire logic    pop,
  output q_item_t      head,
  output logic         empty
);

  q_item_t               entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  do_push, do_pop;

  assign full    = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

FILE: src/sosg_back.sv
// back part: window minimum, stopped detector, pass/stop hysteresis, result register
// depends on sosg_pkg and the assertion macro header
`default_nettype none
`include "surround_obstacle_stop_guard_macros.svh"

module sosg_back import sosg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    q_empty,
  input  wire q_item_t q_head,
  output logic         q_pop,
  output result_t      result,
  output logic         out_valid,
  input  wire logic    pop
);

  typedef enum logic [1:0] {
    ST_PASS = 2'b01,
    ST_STOP = 2'b10
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  state_t                    state, state_next;
  logic [DIST_W-1:0]         min_dist;
  logic signed [POINT_W-1:0] near_x, near_y;
  logic [CNT_W-1:0]          ticks_moving, ticks_found;
  logic                      found_seen;
  logic [2*OFFSET_W-1:0]     check_sq, recover_sq;

  logic                      out_ready, take, take_point, take_tick;
  logic [SPEED_W-1:0]        mag;
  logic [CNT_W-1:0]          ticks_moving_next, ticks_found_inc, ticks_found_next;
  logic                      stopped, was_stop, found, required, seen_next;
  cmd_t                      cmd;

  assign out_ready  = !out_valid || pop;
  assign take       = !q_empty && (q_head.kind == KIND_POINT || out_ready);
  assign take_point = take && q_head.kind == KIND_POINT;
  assign take_tick  = take && q_head.kind == KIND_TICK;
  assign q_pop      = take;

  // thresholds squared into registers from the configuration registers
  always_ff @(posedge clk) begin
    check_sq   <= cfg.check_distance * cfg.check_distance;
    recover_sq <= cfg.recover_distance * cfg.recover_distance;
  end

  always_comb begin
    mag = q_head.speed[SPEED_W-1] ? SPEED_W'(-q_head.speed) : SPEED_W'(q_head.speed);
    if (mag > {1'b0, cfg.stop_speed}) begin
      ticks_moving_next = '0;
    end else begin
      ticks_moving_next = sat_inc(ticks_moving);
    end
    stopped         = ticks_moving_next > CNT_W'(STOP_ENTRY_TICKS);
    ticks_found_inc = sat_inc(ticks_found);
    was_stop        = state == ST_STOP;

    unique case (state)
      ST_PASS: found = min_dist < {{(DIST_W-2*OFFSET_W){1'b0}}, check_sq};
      ST_STOP: found = min_dist <= {{(DIST_W-2*OFFSET_W){1'b0}}, recover_sq};
      default: found = 1'b0;
    endcase

    ticks_found_next = ticks_found_inc;
    seen_next        = found_seen;
    required         = 1'b0;
    if (!stopped) begin
      required = 1'b0;
    end else if (found) begin
      seen_next        = 1'b1;
      ticks_found_next = '0;
      required         = 1'b1;
    end else if (!was_stop) begin
      required = 1'b0;
    end else if (found_seen && ticks_found_inc <= cfg.clear_ticks) begin
      required = 1'b1;
    end else begin
      seen_next = 1'b0;
    end

    state_next = state;
    cmd        = CMD_NONE;
    if (!was_stop && required) begin
      state_next = ST_STOP;
      cmd        = CMD_LIMIT;
    end else if (was_stop && !required) begin
      state_next = ST_PASS;
      cmd        = CMD_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_PASS;
      min_dist     <= DIST_ONES;
      near_x       <= '0;
      near_y       <= '0;
      ticks_moving <= '0;
      found_seen   <= 1'b0;
      ticks_found  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (take_tick) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (take_point && q_head.dist_sq < min_dist) begin
        min_dist <= q_head.dist_sq;
        near_x   <= q_head.x;
        near_y   <= q_head.y;
      end
      if (take_tick) begin
        state        <= state_next;
        ticks_moving <= ticks_moving_next;
        ticks_found  <= ticks_found_next;
        found_seen   <= seen_next;
        min_dist     <= DIST_ONES;
        near_x       <= '0;
        near_y       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      result.stop_active     <= state_next == ST_STOP;
      result.command         <= cmd;
      result.obstacle_found  <= found;
      result.nearest_dist_sq <= min_dist;
      result.nearest_x       <= near_x;
      result.nearest_y       <= near_y;
    end
  end

  `SOSG_ASSERT_NEXT(a_limit_enters_stop, take_tick && cmd == CMD_LIMIT, state == ST_STOP,
    "limit command without entering stop")
  `SOSG_ASSERT_NEXT(a_clear_enters_pass, take_tick && cmd == CMD_CLEAR, state == ST_PASS,
    "clear command without returning to pass")
  `SOSG_ASSERT_NEXT(a_window_cleared, take_tick,
    min_dist == DIST_ONES && near_x == '0 && near_y == '0, "window not cleared after tick")
  `SOSG_ASSERT_NOW(a_no_result_overwrite, out_valid && !pop, !take_tick,
    "waiting result overwritten")

endmodule

`default_nettype wire

FILE: src/surround_obstacle_stop_guard.sv
// top level of the surround obstacle stop guard: configuration registers and wiring
// depends on sosg_pkg, sosg_front, sosg_queue and sosg_back
`default_nettype none

// Obstacle points and ticks enter through one queue-like port and are taken one per
// cycle, back to back, while full is low. The front part spends two register stages
// on an item (rectangle gaps, then the two squares) and drops it into a four-entry
// queue; the back part then takes one item per cycle, save a tick behind an unread
// result, folds points into the window minimum and turns each tick into one result.
// The sustained rate is set by the back part's compare-and-update of the window
// minimum. Points give no result. A result waits in an output register while the
// next items keep flowing; only ticks stall behind an unread result. Register writes
// are meant for idle periods only.
module surround_obstacle_stop_guard import sosg_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         kind,
  input  wire logic signed [POINT_W-1:0]    point_x,
  input  wire logic signed [POINT_W-1:0]    point_y,
  input  wire logic signed [SPEED_W-1:0]    ego_speed,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              stop_active,
  output logic [1:0]                        command,
  output logic                              obstacle_found,
  output logic [DIST_W-1:0]                 nearest_dist_sq,
  output logic signed [POINT_W-1:0]         nearest_x,
  output logic signed [POINT_W-1:0]         nearest_y,
  input  wire logic                         cfg_write,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

  cfg_t    cfg;
  logic    q_push, q_full, q_pop, q_empty, out_valid;
  q_item_t q_in, q_head;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.front_offset     <= 16'sd4000;
      cfg.rear_offset      <= -16'sd1000;
      cfg.left_offset      <= 16'sd1000;
      cfg.right_offset     <= -16'sd1000;
      cfg.check_distance   <= 16'd2000;
      cfg.recover_distance <= 16'd2500;
      cfg.stop_speed       <= 16'd100;
      cfg.clear_ticks      <= 8'd20;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRONT_OFFSET:     cfg.front_offset     <= $signed(cfg_data);
        REG_REAR_OFFSET:      cfg.rear_offset      <= $signed(cfg_data);
        REG_LEFT_OFFSET:      cfg.left_offset      <= $signed(cfg_data);
        REG_RIGHT_OFFSET:     cfg.right_offset     <= $signed(cfg_data);
        REG_CHECK_DISTANCE:   cfg.check_distance   <= cfg_data;
        REG_RECOVER_DISTANCE: cfg.recover_distance <= cfg_data;
        REG_STOP_SPEED:       cfg.stop_speed       <= cfg_data;
        REG_CLEAR_TICKS:      cfg.clear_ticks      <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  sosg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .point_x   (point_x),
    .point_y   (point_y),
    .ego_speed (ego_speed),
    .q_push    (q_push),
    .q_item    (q_in),
    .q_full    (q_full)
  );

  sosg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sosg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .result    (result),
    .out_valid (out_valid),
    .pop       (pop)
  );

  assign empty           = !out_valid;
  assign stop_active     = result.stop_active;
  assign command         = result.command;
  assign obstacle_found  = result.obstacle_found;
  assign nearest_dist_sq = result.nearest_dist_sq;
  assign nearest_x       = result.nearest_x;
  assign nearest_y       = result.nearest_y;

endmodule

`default_nettype wire

FILE: test/stop_guard_check.sv
// checker for the surround obstacle stop guard: watches the input, result and
// register ports, predicts every tick result and compares it field by field
// depends on sosg_pkg
module stop_guard_check import sosg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  logic                      kind,
  input  logic signed [POINT_W-1:0] point_x,
  input  logic signed [POINT_W-1:0] point_y,
  input  logic signed [SPEED_W-1:0] ego_speed,
  input  logic                      empty,
  input  logic                      pop,
  input  logic                      stop_active,
  input  logic [1:0]                command,
  input  logic                      obstacle_found,
  input  logic [DIST_W-1:0]         nearest_dist_sq,
  input  logic signed [POINT_W-1:0] nearest_x,
  input  logic signed [POINT_W-1:0] nearest_y,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output int                        errors,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                      regs;
  logic                      stop_st;
  logic                      found_seen;
  logic [DIST_W-1:0]         win_min;
  logic signed [POINT_W-1:0] win_x;
  logic signed [POINT_W-1:0] win_y;
  logic [CNT_W-1:0]          moving_ticks;
  logic [CNT_W-1:0]          found_ticks;
  result_t                   expected_results[$];

  // distance outside the interval [lo, hi], zero inside
  function automatic longint axis_gap(longint p, longint hi, longint lo);
    longint g;
    g = 0;
    if (p - hi > g) g = p - hi;
    if (lo - p > g) g = lo - p;
    return g;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  task automatic fold_point(logic signed [POINT_W-1:0] x, logic signed [POINT_W-1:0] y);
    longint dx, dy, d;
    dx = axis_gap(longint'(x), longint'($signed(regs.front_offset)),
                  longint'($signed(regs.rear_offset)));
    dy = axis_gap(longint'(y), longint'($signed(regs.left_offset)),
                  longint'($signed(regs.right_offset)));
    d = dx * dx + dy * dy;
    if (d > longint'(DIST_ONES)) d = longint'(DIST_ONES);
    // only a strictly closer point takes over the window minimum
    if (d < longint'(win_min)) begin
      win_min = d[DIST_W-1:0];
      win_x = x;
      win_y = y;
    end
  endtask

  task automatic tick_decide(logic signed [SPEED_W-1:0] speed);
    int      mag;
    logic    stopped, found, required, was_stop;
    longint  chk, rec;
    result_t r;
    mag = (speed < 0) ? -int'(speed) : int'(speed);
    if (mag > int'(regs.stop_speed)) moving_ticks = '0;
    else moving_ticks = sat_inc(moving_ticks);
    stopped = moving_ticks > STOP_ENTRY_TICKS;
    found_ticks = sat_inc(found_ticks);
    was_stop = stop_st;
    chk = longint'(regs.check_distance);
    rec = longint'(regs.recover_distance);
    found = was_stop ? (longint'(win_min) <= rec * rec) : (longint'(win_min) < chk * chk);

    if (!stopped) begin
      required = 1'b0;
    end else if (found) begin
      found_seen = 1'b1;
      found_ticks = '0;
      required = 1'b1;
    end else if (!was_stop) begin
      required = 1'b0;
    end else if (found_seen && found_ticks <= regs.clear_ticks) begin
      required = 1'b1;
    end else begin
      found_seen = 1'b0;
      required = 1'b0;
    end

    r.command = CMD_NONE;
    if (!was_stop && required) begin
      stop_st = 1'b1;
      r.command = CMD_LIMIT;
    end else if (was_stop && !required) begin
      stop_st = 1'b0;
      r.command = CMD_CLEAR;
    end
    r.stop_active = stop_st;
    r.obstacle_found = found;
    r.nearest_dist_sq = win_min;
    r.nearest_x = win_x;
    r.nearest_y = win_y;
    expected_results = {expected_results, r};

    win_min = DIST_ONES;
    win_x = '0;
    win_y = '0;
  endtask

  task automatic check_result();
    result_t e;
    if (expected_results.size() == 0) begin
      $error("result transfer with no expected result pending");
      errors++;
      return;
    end
    e = expected_results.pop_front();
    if (stop_active !== e.stop_active) begin
      $error("stop_active: expected %0d, actual %0d", e.stop_active, stop_active);
      errors++;
    end
    if (command !== e.command) begin
      $error("command: expected %0d, actual %0d", e.command, command);
      errors++;
    end
    if (obstacle_found !== e.obstacle_found) begin
      $error("obstacle_found: expected %0d, actual %0d", e.obstacle_found, obstacle_found);
      errors++;
    end
    if (nearest_dist_sq !== e.nearest_dist_sq) begin
      $error("nearest_dist_sq: expected %0d, actual %0d", e.nearest_dist_sq, nearest_dist_sq);
      errors++;
    end
    if (nearest_x !== e.nearest_x) begin
      $error("nearest_x: expected %0d, actual %0d", e.nearest_x, nearest_x);
      errors++;
    end
    if (nearest_y !== e.nearest_y) begin
      $error("nearest_y: expected %0d, actual %0d", e.nearest_y, nearest_y);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.front_offset = 16'sd4000;
      regs.rear_offset = -16'sd1000;
      regs.left_offset = 16'sd1000;
      regs.right_offset = -16'sd1000;
      regs.check_distance = 16'd2000;
      regs.recover_distance = 16'd2500;
      regs.stop_speed = 16'd100;
      regs.clear_ticks = 8'd20;
      stop_st = 1'b0;
      found_seen = 1'b0;
      win_min = DIST_ONES;
      win_x = '0;
      win_y = '0;
      moving_ticks = '0;
      found_ticks = '0;
      errors = 0;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRONT_OFFSET:     regs.front_offset = cfg_data;
          REG_REAR_OFFSET:      regs.rear_offset = cfg_data;
          REG_LEFT_OFFSET:      regs.left_offset = cfg_data;
          REG_RIGHT_OFFSET:     regs.right_offset = cfg_data;
          REG_CHECK_DISTANCE:   regs.check_distance = cfg_data;
          REG_RECOVER_DISTANCE: regs.recover_distance = cfg_data;
          REG_STOP_SPEED:       regs.stop_speed = cfg_data;
          REG_CLEAR_TICKS:      regs.clear_ticks = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting so a result can never match a tick of the same edge
      if (pop && !empty) check_result();
      if (push && !full) begin
        if (kind == KIND_TICK) tick_decide(ego_speed);
        else fold_point(point_x, point_y);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: test/surround_obstacle_stop_guard_tb.sv
// testbench top for the surround obstacle stop guard: clock, reset, stimulus,
// result draining and verdict; prediction and comparison live in stop_guard_check
// depends on sosg_pkg, surround_obstacle_stop_guard and stop_guard_check
module surround_obstacle_stop_guard_tb import sosg_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 275;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 5000;
  localparam int MAX_GAP       = 5;

  localparam logic signed [POINT_W-1:0] POINT_MIN = POINT_W'(-(2 ** (POINT_W - 1)));
  localparam logic signed [POINT_W-1:0] POINT_MAX = POINT_W'(2 ** (POINT_W - 1) - 1);
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = SPEED_W'(-(2 ** (SPEED_W - 1)));
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = SPEED_W'(2 ** (SPEED_W - 1) - 1);

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      push;
  logic                      full;
  logic                      kind;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic signed [SPEED_W-1:0] ego_speed;
  logic                      empty;
  logic                      pop;
  logic                      stop_active;
  logic [1:0]                command;
  logic                      obstacle_found;
  logic [DIST_W-1:0]         nearest_dist_sq;
  logic signed [POINT_W-1:0] nearest_x;
  logic signed [POINT_W-1:0] nearest_y;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  int   errors;
  int   outstanding;
  int   idle_cycles = 0;
  int   hold_left = 0;
  logic rush = 1'b0;
  cfg_t cur_cfg;
  int   phase_items;
  logic obst_near;
  logic moving;

  always #5 clk = ~clk;

  surround_obstacle_stop_guard dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .kind(kind), .point_x(point_x), .point_y(point_y), .ego_speed(ego_speed),
    .empty(empty), .pop(pop),
    .stop_active(stop_active), .command(command), .obstacle_found(obstacle_found),
    .nearest_dist_sq(nearest_dist_sq), .nearest_x(nearest_x), .nearest_y(nearest_y),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stop_guard_check guard_check (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .kind(kind), .point_x(point_x), .point_y(point_y), .ego_speed(ego_speed),
    .empty(empty), .pop(pop),
    .stop_active(stop_active), .command(command), .obstacle_found(obstacle_found),
    .nearest_dist_sq(nearest_dist_sq), .nearest_x(nearest_x), .nearest_y(nearest_y),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  // watchdog: cycles without any transfer on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random pauses, stretches without pauses, one long hold-off
  initial begin
    int   pause;
    logic popped;
    pop = 1'b0;
    pause = 0;
    popped = 1'b0;
    forever begin
      @(posedge clk);
      popped = pop && !empty;
      @(negedge clk);
      if (rst) begin
        pop = 1'b0;
      end else if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else if (popped || !pop) begin
        if (popped) pause = rush ? 0 : $urandom_range(MAX_GAP);
        if (pause > 0) begin
          pop = 1'b0;
          pause--;
        end else begin
          pop = 1'b1;
        end
      end
    end
  end

  function automatic logic signed [POINT_W-1:0] any_coord();
    logic [31:0] r;
    r = $urandom;
    return r[POINT_W-1:0];
  endfunction

  function automatic logic signed [SPEED_W-1:0] any_speed();
    logic [31:0] r;
    r = $urandom;
    return r[SPEED_W-1:0];
  endfunction

  // coordinate around the interval spanned by two rectangle edges
  function automatic logic signed [POINT_W-1:0] near_coord(int a, int b, int span);
    int lo, hi, v;
    lo = ((a < b) ? a : b) - span;
    hi = ((a < b) ? b : a) + span;
    if (lo < int'(POINT_MIN)) lo = int'(POINT_MIN);
    if (hi > int'(POINT_MAX)) hi = int'(POINT_MAX);
    v = lo + int'($urandom_range(hi - lo));
    return v[POINT_W-1:0];
  endfunction

  function automatic logic signed [SPEED_W-1:0] draw_speed(logic fast);
    int mag, v;
    if (fast) mag = int'(cur_cfg.stop_speed) + 1 + int'($urandom_range(65535 - cur_cfg.stop_speed));
    else mag = $urandom_range(cur_cfg.stop_speed);
    v = ($urandom_range(1) == 1) ? -mag : mag;
    if (v > int'(SPEED_MAX)) v = int'(SPEED_MAX);
    return v[SPEED_W-1:0];
  endfunction

  function automatic cfg_t moderate_cfg();
    cfg_t c;
    int   chk;
    chk = 300 + int'($urandom_range(3700));
    c.front_offset = OFFSET_W'(500 + int'($urandom_range(5500)));
    c.rear_offset = OFFSET_W'(-int'($urandom_range(3000)));
    c.left_offset = OFFSET_W'(200 + int'($urandom_range(1800)));
    c.right_offset = OFFSET_W'(-200 - int'($urandom_range(1800)));
    c.check_distance = OFFSET_W'(chk);
    c.recover_distance = OFFSET_W'(chk + int'($urandom_range(2000)));
    c.stop_speed = OFFSET_W'($urandom_range(500));
    c.clear_ticks = CNT_W'($urandom_range(40));
    return c;
  endfunction

  function automatic cfg_t make_cfg(int ph);
    cfg_t c;
    c = moderate_cfg();
    case (ph)
      1: begin
        // huge rectangle, widest thresholds, stop held as long as stopped
        c.front_offset = 16'sh7fff;
        c.rear_offset = 16'sh8000;
        c.left_offset = 16'sh7fff;
        c.right_offset = 16'sh8000;
        c.check_distance = '1;
        c.recover_distance = '1;
        c.stop_speed = '1;
        c.clear_ticks = '1;
      end
      2: begin
        // swapped edges, zero thresholds
        c.front_offset = 16'sh8000;
        c.rear_offset = 16'sh7fff;
        c.left_offset = 16'sh8000;
        c.right_offset = 16'sh7fff;
        c.check_distance = '0;
        c.recover_distance = '0;
        c.stop_speed = '0;
        c.clear_ticks = '0;
      end
      3: begin
        c.front_offset = OFFSET_W'($urandom);
        c.rear_offset = OFFSET_W'($urandom);
        c.left_offset = OFFSET_W'($urandom);
        c.right_offset = OFFSET_W'($urandom);
        c.check_distance = OFFSET_W'($urandom);
        c.recover_distance = OFFSET_W'($urandom);
        c.stop_speed = OFFSET_W'($urandom);
        c.clear_ticks = CNT_W'($urandom);
      end
      4: c.clear_ticks = '1;
      5: begin
        c.stop_speed = '0;
        c.clear_ticks = '0;
      end
      default: ;
    endcase
    return c;
  endfunction

  // offer one item and hold it until the transfer
  task automatic offer(logic k, logic signed [POINT_W-1:0] x, logic signed [POINT_W-1:0] y,
                       logic signed [SPEED_W-1:0] s);
    int gap;
    gap = rush ? 0 : $urandom_range(MAX_GAP);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    kind = k;
    point_x = x;
    point_y = y;
    ego_speed = s;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic point(logic signed [POINT_W-1:0] x, logic signed [POINT_W-1:0] y);
    offer(KIND_POINT, x, y, any_speed());
  endtask

  task automatic tick(logic signed [SPEED_W-1:0] s);
    offer(KIND_TICK, any_coord(), any_coord(), s);
  endtask

  // wait for every expected result, then let points still in flight settle
  task automatic drain();
    push = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
  endtask

  task automatic program_regs(cfg_t c);
    drain();
    write_reg(REG_FRONT_OFFSET, c.front_offset);
    write_reg(REG_REAR_OFFSET, c.rear_offset);
    write_reg(REG_LEFT_OFFSET, c.left_offset);
    write_reg(REG_RIGHT_OFFSET, c.right_offset);
    write_reg(REG_CHECK_DISTANCE, c.check_distance);
    write_reg(REG_RECOVER_DISTANCE, c.recover_distance);
    write_reg(REG_STOP_SPEED, c.stop_speed);
    write_reg(REG_CLEAR_TICKS, {{(CFG_DATA_W-CNT_W){1'b0}}, c.clear_ticks});
    // an index past the last register must change nothing
    write_reg(CFG_IDX_W'(REG_CLEAR_TICKS + 1 + $urandom_range(7)), CFG_DATA_W'($urandom));
    cfg_write = 1'b0;
    cur_cfg = c;
  endtask

  // mostly a window of points closed by a tick, now and then a random item
  task automatic random_window();
    int span, n;
    if ($urandom_range(7) == 0) begin
      offer(1'($urandom_range(1)), any_coord(), any_coord(), any_speed());
      phase_items++;
      return;
    end
    span = int'(cur_cfg.recover_distance) + 1000;
    n = $urandom_range(6);
    repeat (n) begin
      if (obst_near && $urandom_range(3) != 0)
        point(near_coord($signed(cur_cfg.front_offset), $signed(cur_cfg.rear_offset), span),
              near_coord($signed(cur_cfg.left_offset), $signed(cur_cfg.right_offset), span));
      else
        point(any_coord(), any_coord());
    end
    tick(draw_speed(moving));
    phase_items += n + 1;
    if ($urandom_range(7) == 0) obst_near = ~obst_near;
    if ($urandom_range(9) == 0) moving = ~moving;
  endtask

  initial begin
    logic pressed;
    rst = 1'b1;
    push = 1'b0;
    kind = KIND_POINT;
    point_x = '0;
    point_y = '0;
    ego_speed = '0;
    cfg_write = 1'b0;
    cfg_index = REG_FRONT_OFFSET;
    cfg_data = '0;
    pressed = 1'b0;
    obst_near = 1'b1;
    moving = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed part on the reset settings
    offer(KIND_TICK, POINT_MAX, POINT_MAX, 17'sd0);        // empty window
    offer(KIND_POINT, 20'sd0, 20'sd0, SPEED_MIN);          // inside
    point(20'sd100, 20'sd100);                             // equal distance keeps first
    point(POINT_MIN, POINT_MIN);                           // far corner
    offer(KIND_TICK, POINT_MIN, POINT_MIN, 17'sd0);        // stopped, enter stop
    offer(KIND_POINT, POINT_MAX, POINT_MAX, SPEED_MAX);
    offer(KIND_TICK, 20'sd0, 20'sd0, SPEED_MIN);           // moving, leave stop
    offer(KIND_TICK, POINT_MAX, POINT_MIN, SPEED_MAX);
    offer(KIND_TICK, POINT_MIN, POINT_MAX, 17'sd100);      // speed at threshold is still
    point(20'sd5000, 20'sd0);
    tick(-17'sd100);                                       // enter stop on check distance
    point(20'sd6400, 20'sd0);
    tick(-17'sd100);                                       // kept by recover distance
    point(20'sd6600, 20'sd0);
    tick(17'sd0);                                          // kept by hold timer
    point(-20'sd1000, 20'sd1000);                          // on the corner
    point(-20'sd1001, -20'sd1001);
    tick(17'sd0);
    tick(17'sd0);
    tick(17'sd101);                                        // just above threshold
    point(20'sd4000, 20'sd2999);
    tick(17'sd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      program_regs(make_cfg(ph));
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        rush = ((phase_items / 60) % 3) == 2;
        // receiver stops reading for a while so the block backs up
        if (ph == 0 && !pressed && phase_items >= 100) begin
          pressed = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        random_window();
      end
      rush = 1'b0;
    end

    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
